// File: rtl/hsl_ls_pkg.sv
// types and constants shared by the hsl lightness/saturation pipeline
// no dependencies; used by hsl_ls_div_step and hsl_lightness_saturation
package hsl_ls_pkg;

    localparam int CHAN_WIDTH  = 8;
    localparam int SUM_WIDTH   = CHAN_WIDTH + 1;
    localparam int QUO_WIDTH   = 16;

    localparam logic [SUM_WIDTH-1:0] SAT_SCALE   = 9'd255;
    localparam logic [SUM_WIDTH-1:0] BRIGHT_BASE = 9'd511;
    localparam logic [SUM_WIDTH-1:0] HALF_LEVEL  = 9'd128;

    // quotient bits resolved by each divider stage
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES          = QUO_WIDTH / DIV_STEPS_PER_STAGE;

    typedef struct packed {
        logic [CHAN_WIDTH-1:0] red;
        logic [CHAN_WIDTH-1:0] green;
        logic [CHAN_WIDTH-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] lightness_twice;
        logic [QUO_WIDTH-1:0] saturation_q8;
    } t_result;

    // one transaction in flight through the divider
    typedef struct packed {
        logic                  valid;
        logic [SUM_WIDTH-1:0]  lightness_twice;
        logic [CHAN_WIDTH-1:0] den;
        logic [CHAN_WIDTH-1:0] rem;
        logic [QUO_WIDTH-1:0]  acc;   // pending dividend bits shift out, quotient bits shift in
    } t_div_slot;

endpackage

// File: rtl/hsl_ls_div_step.sv
// one registered stage of the restoring divider, DIV_STEPS_PER_STAGE (4) quotient bits per stage
// depends on hsl_ls_pkg
module hsl_ls_div_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsl_ls_pkg::t_div_slot i_slot,
    output hsl_ls_pkg::t_div_slot o_slot
);
    import hsl_ls_pkg::*;

    t_div_slot r_slot;
    t_div_slot n_slot;

    always_comb begin
        logic [CHAN_WIDTH:0] trial;
        logic                qbit;
        n_slot = i_slot;
        for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
            trial = {n_slot.rem, n_slot.acc[QUO_WIDTH-1]};
            qbit  = (trial >= {1'b0, n_slot.den});
            if (qbit) begin
                trial = trial - {1'b0, n_slot.den};
            end
            // remainder stays below den, so it fits the channel width
            n_slot.rem = trial[CHAN_WIDTH-1:0];
            n_slot.acc = {n_slot.acc[QUO_WIDTH-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.lightness_twice <= n_slot.lightness_twice;
        r_slot.den             <= n_slot.den;
        r_slot.rem             <= n_slot.rem;
        r_slot.acc             <= n_slot.acc;
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

    assign o_slot = r_slot;

endmodule

// File: rtl/hsl_lightness_saturation.sv
// top level: hsl lightness (doubled) and saturation of an 8-bit rgb pixel
// depends on hsl_ls_pkg and hsl_ls_div_step
//
//  channel   ports                       direction  handshake
//  pixel     start, busy, i_pixel        in         taken when start && !busy
//  result    o_strobe, o_result          out        one cycle per result, no backpressure
//
// a pixel can enter every cycle; busy is always low
// registered pipeline steps: max/min, sum/den, scaling, then the
// 16-bit restoring divider resolving 4 quotient bits per stage
// synchronous active-low reset clears only the valid bits along the pipe
module hsl_lightness_saturation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  hsl_ls_pkg::t_pixel i_pixel,
    output logic               o_strobe,
    output hsl_ls_pkg::t_result o_result
);
    import hsl_ls_pkg::*;

    // stage 1: max and min channel
    logic                  r_s1_valid;
    logic [CHAN_WIDTH-1:0] r_s1_hi;
    logic [CHAN_WIDTH-1:0] r_s1_lo;
    logic [CHAN_WIDTH-1:0] n_s1_hi;
    logic [CHAN_WIDTH-1:0] n_s1_lo;
    logic [CHAN_WIDTH-1:0] w_rg_hi;
    logic [CHAN_WIDTH-1:0] w_rg_lo;

    // stage 2: sum, difference, denominator
    logic                  r_s2_valid;
    logic [SUM_WIDTH-1:0]  r_s2_sum;
    logic [CHAN_WIDTH-1:0] r_s2_diff;
    logic [CHAN_WIDTH-1:0] r_s2_den;
    logic [SUM_WIDTH-1:0]  n_s2_sum;
    logic [SUM_WIDTH-1:0]  n_s2_den_full;
    logic [CHAN_WIDTH-1:0] n_s2_den;

    // stage 3: scaled numerator loaded into the divider slot
    t_div_slot             r_s3_slot;
    t_div_slot             n_s3_slot;
    logic [QUO_WIDTH-1:0]  w_num;

    t_div_slot             w_slot [0:DIV_STAGES];

    assign busy = 1'b0;

    assign w_rg_hi = (i_pixel.red > i_pixel.green) ? i_pixel.red : i_pixel.green;
    assign w_rg_lo = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
    assign n_s1_hi = (w_rg_hi > i_pixel.blue) ? w_rg_hi : i_pixel.blue;
    assign n_s1_lo = (w_rg_lo < i_pixel.blue) ? w_rg_lo : i_pixel.blue;

    always_ff @(posedge i_clk) begin
        r_s1_hi <= n_s1_hi;
        r_s1_lo <= n_s1_lo;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_comb begin
        n_s2_sum = {1'b0, r_s1_hi} + {1'b0, r_s1_lo};
        if (n_s2_sum >= (HALF_LEVEL << 1)) begin
            n_s2_den_full = BRIGHT_BASE - n_s2_sum;
        end else begin
            n_s2_den_full = n_s2_sum;
        end
        // black pixel: numerator is zero, a divisor of one gives zero
        if (n_s2_den_full == '0) begin
            n_s2_den = CHAN_WIDTH'(1);
        end else begin
            n_s2_den = n_s2_den_full[CHAN_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sum  <= n_s2_sum;
        r_s2_diff <= r_s1_hi - r_s1_lo;
        r_s2_den  <= n_s2_den;
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // diff * 255; the full dividend is this value times 256
    assign w_num = {r_s2_diff, {CHAN_WIDTH{1'b0}}}
                 - {{(QUO_WIDTH-CHAN_WIDTH){1'b0}}, r_s2_diff};

    always_comb begin
        n_s3_slot.valid           = r_s2_valid;
        n_s3_slot.lightness_twice = r_s2_sum;
        n_s3_slot.den             = r_s2_den;
        // upper dividend bits are already below den since diff <= den
        n_s3_slot.rem             = w_num[QUO_WIDTH-1:CHAN_WIDTH];
        n_s3_slot.acc             = {w_num[CHAN_WIDTH-1:0],
                                     {(QUO_WIDTH-CHAN_WIDTH){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_s3_slot.lightness_twice <= n_s3_slot.lightness_twice;
        r_s3_slot.den             <= n_s3_slot.den;
        r_s3_slot.rem             <= n_s3_slot.rem;
        r_s3_slot.acc             <= n_s3_slot.acc;
        if (!i_rst_n) begin
            r_s3_slot.valid <= 1'b0;
        end else begin
            r_s3_slot.valid <= n_s3_slot.valid;
        end
    end

    assign w_slot[0] = r_s3_slot;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_div
            hsl_ls_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_slot  (w_slot[g]),
                .o_slot  (w_slot[g+1])
            );
        end
    endgenerate

    assign o_strobe                 = w_slot[DIV_STAGES].valid;
    assign o_result.lightness_twice = w_slot[DIV_STAGES].lightness_twice;
    assign o_result.saturation_q8   = w_slot[DIV_STAGES].acc;

endmodule
